### rtl/html_text_escaper_core_assert.svh
// assertion macros used by the checker file
`ifndef HTML_TEXT_ESCAPER_CORE_ASSERT_SVH
`define HTML_TEXT_ESCAPER_CORE_ASSERT_SVH

// same-cycle implication, off while reset is asserted
`define HTE_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("html escaper check failed");

// next-cycle implication, off while reset is asserted
`define HTE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("html escaper check failed");

// next-cycle implication that also holds through reset
`define HTE_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("html escaper check failed");

`endif

### rtl/hte_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package hte_pkg;

    localparam logic [15:0] UNIT_CR  = 16'h000D;
    localparam logic [15:0] UNIT_LF  = 16'h000A;
    localparam logic [15:0] UNIT_AMP = 16'h0026;
    localparam logic [15:0] UNIT_LT  = 16'h003C;
    localparam logic [15:0] UNIT_GT  = 16'h003E;

    // register index of the line-break control
    localparam logic REG_CONVERT_LINE_BREAKS = 1'b0;

    typedef enum logic [2:0] {
        KIND_PASS,
        KIND_AMP,
        KIND_LT,
        KIND_GT,
        KIND_BR,
        KIND_DROP
    } esc_kind_t;

    typedef logic [2:0] seq_idx_t;

    // number of units produced for an escape sequence
    function automatic seq_idx_t seq_len(input esc_kind_t kind);
        seq_idx_t n;
        case (kind)
            KIND_AMP: n = 3'd5;
            KIND_LT:  n = 3'd4;
            KIND_GT:  n = 3'd4;
            KIND_BR:  n = 3'd5;
            default:  n = 3'd1;
        endcase
        return n;
    endfunction

    // unit at position idx of an escape sequence
    function automatic logic [15:0] seq_char(input esc_kind_t kind, input seq_idx_t idx);
        logic [7:0] c;
        c = 8'h00;
        case (kind)
            KIND_AMP: begin
                case (idx)
                    3'd0: c = "&";
                    3'd1: c = "a";
                    3'd2: c = "m";
                    3'd3: c = "p";
                    default: c = ";";
                endcase
            end
            KIND_LT: begin
                case (idx)
                    3'd0: c = "&";
                    3'd1: c = "l";
                    3'd2: c = "t";
                    default: c = ";";
                endcase
            end
            KIND_GT: begin
                case (idx)
                    3'd0: c = "&";
                    3'd1: c = "g";
                    3'd2: c = "t";
                    default: c = ";";
                endcase
            end
            KIND_BR: begin
                case (idx)
                    3'd0: c = "<";
                    3'd1: c = "b";
                    3'd2: c = "r";
                    3'd3: c = "/";
                    default: c = ">";
                endcase
            end
            default: c = 8'h00;
        endcase
        return {8'h00, c};
    endfunction

endpackage
`default_nettype wire

### rtl/hte_classify.sv
`timescale 1ns / 1ps
`default_nettype none
module hte_classify
    import hte_pkg::*;
(
    input  wire logic [15:0] unit,
    input  wire logic        conv,
    input  wire logic        pending_cr,
    output esc_kind_t        kind
);

    always_comb begin
        if (unit == UNIT_AMP) begin
            kind = KIND_AMP;
        end else if (unit == UNIT_LT) begin
            kind = KIND_LT;
        end else if (unit == UNIT_GT) begin
            kind = KIND_GT;
        end else if (conv && unit == UNIT_LF && pending_cr) begin
            kind = KIND_DROP;
        end else if (conv && (unit == UNIT_CR || unit == UNIT_LF)) begin
            kind = KIND_BR;
        end else begin
            kind = KIND_PASS;
        end
    end

endmodule
`default_nettype wire

### rtl/html_text_escaper_core.sv
`timescale 1ns / 1ps
`default_nettype none
// channel   | dir | tdata                  | tlast         | handshake
// ----------+-----+------------------------+---------------+----------------
// s_        | in  | [15:0] text_unit       | end_of_string | s_tvalid/s_tready
// m_        | out | [15:0] out_unit        | last_of_run   | m_tvalid/m_tready
// apb       | in  | pwdata[0] convert_line_breaks at byte address 0
//
// plain units flow at one item per cycle while the output is not stalled; an escaped
//   unit holds the input until its sequence of four or five units has gone out, fed
//   by the expander into the single output register one unit per cycle unless stalled
// an lf dropped after a converted cr produces no output
// aresetn is synchronous, active low; clears valids, busy state, pending cr
//   and the line-break control
// an input register lets one item wait while the output is stalled
module html_text_escaper_core
    import hte_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // [15:0] text_unit
    input  wire logic        s_tlast,   // end_of_string

    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [15:0] m_tdata,   // [15:0] out_unit
    output logic             m_tlast,   // last_of_run

    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic  [2:0] paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    // configuration
    logic conv_reg;

    // input register
    logic        in_valid_reg;
    logic [15:0] in_unit_reg;
    logic        in_eos_reg;

    // expander state: sequence in flight and the next position to emit
    logic      busy_reg, busy_next;
    esc_kind_t bkind_reg, bkind_next;
    seq_idx_t  idx_reg, idx_next;

    logic pending_cr_reg, pending_cr_next;

    // output register
    logic        out_valid_reg, out_valid_next;
    logic [15:0] out_unit_reg, out_unit_next;
    logic        out_last_reg, out_last_next;

    esc_kind_t kind;
    logic      out_can_load;
    logic      consume;
    logic      in_take;
    logic      cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == REG_CONVERT_LINE_BREAKS) ? {31'd0, conv_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            conv_reg <= 1'b0;
        end else if (cfg_write && paddr[2] == REG_CONVERT_LINE_BREAKS) begin
            conv_reg <= pwdata[0];
        end
    end

    hte_classify u_classify (
        .unit       (in_unit_reg),
        .conv       (conv_reg),
        .pending_cr (pending_cr_reg),
        .kind       (kind)
    );

    assign out_can_load = !out_valid_reg || m_tready;

    // the waiting item leaves the input register when it starts; a dropped lf
    // needs no output slot
    assign consume  = in_valid_reg && !busy_reg && (kind == KIND_DROP || out_can_load);
    assign s_tready = !in_valid_reg || consume;
    assign in_take  = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (in_take) begin
            in_valid_reg <= 1'b1;
        end else if (consume) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_take) begin
            in_unit_reg <= s_tdata;
            in_eos_reg  <= s_tlast;
        end
    end

    // pending cr follows each consumed item
    always_comb begin
        pending_cr_next = pending_cr_reg;
        if (consume) begin
            pending_cr_next = conv_reg && in_unit_reg == UNIT_CR && !in_eos_reg;
        end
    end

    // expander and output register
    always_comb begin
        busy_next      = busy_reg;
        bkind_next     = bkind_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_unit_next  = out_unit_reg;
        out_last_next  = out_last_reg;
        if (busy_reg) begin
            if (out_can_load) begin
                out_valid_next = 1'b1;
                out_unit_next  = seq_char(bkind_reg, idx_reg);
                out_last_next  = (idx_reg == seq_len(bkind_reg) - 3'd1);
                if (idx_reg == seq_len(bkind_reg) - 3'd1) begin
                    busy_next = 1'b0;
                end else begin
                    idx_next = idx_reg + 3'd1;
                end
            end
        end else if (consume && kind != KIND_DROP) begin
            out_valid_next = 1'b1;
            if (kind == KIND_PASS) begin
                out_unit_next = in_unit_reg;
                out_last_next = 1'b1;
            end else begin
                // first unit goes out now, the rest from the expander
                out_unit_next = seq_char(kind, 3'd0);
                out_last_next = 1'b0;
                busy_next     = 1'b1;
                bkind_next    = kind;
                idx_next      = 3'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
            pending_cr_reg <= 1'b0;
        end else begin
            busy_reg       <= busy_next;
            out_valid_reg  <= out_valid_next;
            pending_cr_reg <= pending_cr_next;
        end
    end

    always_ff @(posedge aclk) begin
        bkind_reg    <= bkind_next;
        idx_reg      <= idx_next;
        out_unit_reg <= out_unit_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_unit_reg;
    assign m_tlast  = out_last_reg;

endmodule
`default_nettype wire

### rtl/hte_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "html_text_escaper_core_assert.svh"
module hte_checker
    import hte_pkg::*;
(
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [15:0] m_tdata,
    input wire logic        m_tlast
);

    // a stalled result stays offered
    `HTE_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid)
    // nothing is offered right after reset
    `HTE_ASSERT_NEXT_ALWAYS(a_reset_idle, aclk, !aresetn, !m_tvalid)
    // an ampersand or less-than only appears inside an escape sequence
    `HTE_ASSERT_IMPL(a_amp_not_last, aclk, aresetn,
        m_tvalid && (m_tdata == UNIT_AMP || m_tdata == UNIT_LT), !m_tlast)
    // a sequence continues without a gap once its first unit is taken
    `HTE_ASSERT_NEXT(a_seq_no_gap, aclk, aresetn,
        m_tvalid && m_tready && !m_tlast, m_tvalid)

endmodule

bind html_text_escaper_core hte_checker u_hte_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
`default_nettype wire
